@@ sv/mbsc_pkg.sv @@
`default_nettype none

package mbsc_pkg;

    // CRC-16-CCITT, MSB first, no reflection.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Four ones follow the CRC.
    localparam logic [15:0] TRAILER_WORD = 16'h000F;
    localparam logic [4:0]  TRAILER_BITS = 5'd4;
    localparam logic [4:0]  CRC_BITS     = 5'd16;
    localparam logic [4:0]  MAX_PIECE    = 5'd16;

    // Distance past the message end at which the trailer starts.
    localparam logic signed [12:0] REM_TRAILER = -13'sd16;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int APB_AW    = 5;

    typedef enum logic {
        OP_NEXT_BIT = 1'b0,
        OP_WRITE    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        REG_MESSAGE_BITS = 3'd0,
        REG_CHAR_BITS    = 3'd1,
        REG_CRC_ON       = 3'd2,
        REG_REPEAT_ON    = 3'd3,
        REG_LEAD_PATTERN = 3'd4,
        REG_LEAD_COUNT   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [10:0] message_bits;
        logic [4:0]  char_bits;
        logic        crc_on;
        logic        repeat_on;
        logic [15:0] lead_pattern;
        logic [4:0]  lead_count;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_REREAD,
        ST_LOOK_AGAIN
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic wr;
        logic step;
        logic second_pass;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;
        logic need_reread;
    } stat_t;

    // One CRC step over a single message bit.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic b);
        logic fb;
        logic [15:0] c;
        fb = crc[15] ^ b;
        c  = {crc[14:0], 1'b0};
        if (fb) begin
            c = c ^ CRC_POLY;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/mbsc_regs.sv @@
`default_nettype none

module mbsc_regs
    import mbsc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.message_bits <= 11'd0;
            cfg_reg.char_bits    <= 5'd10;
            cfg_reg.crc_on       <= 1'b0;
            cfg_reg.repeat_on    <= 1'b0;
            cfg_reg.lead_pattern <= 16'd0;
            cfg_reg.lead_count   <= 5'd0;
        end else if (wr_en) begin
            unique case (idx)
                REG_MESSAGE_BITS: cfg_reg.message_bits <= pwdata[10:0];
                REG_CHAR_BITS:    cfg_reg.char_bits    <= pwdata[4:0];
                REG_CRC_ON:       cfg_reg.crc_on       <= pwdata[0];
                REG_REPEAT_ON:    cfg_reg.repeat_on    <= pwdata[0];
                REG_LEAD_PATTERN: cfg_reg.lead_pattern <= pwdata[15:0];
                REG_LEAD_COUNT:   cfg_reg.lead_count   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        prdata = 32'd0;
        unique case (idx)
            REG_MESSAGE_BITS: prdata = 32'(cfg_reg.message_bits);
            REG_CHAR_BITS:    prdata = 32'(cfg_reg.char_bits);
            REG_CRC_ON:       prdata = 32'(cfg_reg.crc_on);
            REG_REPEAT_ON:    prdata = 32'(cfg_reg.repeat_on);
            REG_LEAD_PATTERN: prdata = 32'(cfg_reg.lead_pattern);
            REG_LEAD_COUNT:   prdata = 32'(cfg_reg.lead_count);
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/mbsc_ctrl.sv @@
`default_nettype none

module mbsc_ctrl
    import mbsc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_op,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next      = state_reg;
        s_tready        = 1'b0;
        cmd.wr          = 1'b0;
        cmd.step        = 1'b0;
        cmd.second_pass = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (op_t'(s_op) == OP_WRITE) begin
                        cmd.wr = 1'b1;
                    end else begin
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK: begin
                // Wait until the output register can take the result.
                if (!stat.out_busy) begin
                    cmd.step = 1'b1;
                    if (stat.need_reread) begin
                        state_next = ST_REREAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REREAD: begin
                // The store read of the first slot lands this cycle.
                state_next = ST_LOOK_AGAIN;
            end
            ST_LOOK_AGAIN: begin
                if (!stat.out_busy) begin
                    cmd.step        = 1'b1;
                    cmd.second_pass = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/mbsc_dpath.sv @@
`default_nettype none

module mbsc_dpath
    import mbsc_pkg::*;
#(
    parameter int MSG_CHARS  = 64,
    parameter int CHAR_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    input  wire logic [5:0]  char_index,
    input  wire logic [15:0] char_value,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_bit,
    output logic             m_done,
    output logic [15:0]      m_count
);

    localparam int SLOT_W = (MSG_CHARS > 1) ? $clog2(MSG_CHARS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MSG_CHARS - 1);

    // Message store and its registered read port.
    logic [CHAR_WIDTH-1:0] store_mem [MSG_CHARS];
    logic [CHAR_WIDTH-1:0] rd_reg;

    logic [15:0]       shift_reg,    shift_next;
    logic [4:0]        owed_reg,     owed_next;
    logic [11:0]       pos_reg,      pos_next;
    logic [6:0]        cursor_reg,   cursor_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [15:0]       crc_reg,      crc_next;
    logic [15:0]       restarts_reg, restarts_next;
    logic              src_reg,      src_next;
    logic              m_valid_reg;
    logic              m_bit_reg;
    logic              m_done_reg;
    logic [15:0]       m_count_reg;

    logic [15:0]        rd_word;
    logic [4:0]         cb;
    logic [4:0]         lc;
    logic signed [12:0] rem;
    logic               rem_pos;
    logic               cb_fits;
    logic [4:0]         loaded;
    logic [15:0]        sh;
    logic [4:0]         ow;
    logic [4:0]         ow_m1;
    logic               src;
    logic               fail;
    logic               restart;
    logic               bit_val;
    logic               done_val;
    logic               need_reread;

    always_ff @(posedge aclk) begin
        if (cmd.wr && (32'(char_index) < MSG_CHARS)) begin
            store_mem[SLOT_W'(char_index)] <= char_value[CHAR_WIDTH-1:0];
        end
        rd_reg <= store_mem[slot_reg];
    end

    assign rd_word = 16'(rd_reg);

    // Clamped widths and the distance to the message end.
    assign cb = (cfg.char_bits == 5'd0) ? 5'd1 :
                (cfg.char_bits > MAX_PIECE) ? MAX_PIECE : cfg.char_bits;
    assign lc = (cfg.lead_count > MAX_PIECE) ? MAX_PIECE : cfg.lead_count;
    assign rem = $signed({2'b00, cfg.message_bits}) - $signed({1'b0, pos_reg});
    assign rem_pos = !rem[12] && (rem != 13'sd0);
    assign cb_fits = rem_pos && (13'(cb) <= $unsigned(rem));
    assign loaded = cb_fits ? cb : rem[4:0];

    // Piece selection, restart and the bit taken in this step.
    always_comb begin
        shift_next    = shift_reg;
        owed_next     = owed_reg;
        pos_next      = pos_reg;
        cursor_next   = cursor_reg;
        slot_next     = slot_reg;
        crc_next      = crc_reg;
        restarts_next = restarts_reg;
        src_next      = src_reg;
        sh            = shift_reg;
        ow            = owed_reg;
        src           = src_reg;
        fail          = 1'b0;

        if (owed_reg == 5'd0) begin
            priority if (rem_pos) begin
                // Next character, cut to what remains of the message.
                sh       = rd_word;
                ow       = loaded;
                src      = cfg.crc_on;
                pos_next = pos_reg + 12'(loaded);
                if (cb_fits) begin
                    cursor_next = cursor_reg + 7'd1;
                    if ((cursor_reg == 7'h7F) || (slot_reg == SLOT_LAST)) begin
                        slot_next = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end else if ((rem == 13'sd0) && cfg.crc_on) begin
                sh       = crc_reg;
                ow       = CRC_BITS;
                src      = 1'b0;
                pos_next = pos_reg + 12'(CRC_BITS);
            end else if (rem == REM_TRAILER) begin
                sh       = TRAILER_WORD;
                ow       = TRAILER_BITS;
                src      = 1'b0;
                pos_next = pos_reg + 12'(TRAILER_BITS);
            end else begin
                fail = 1'b1;
            end
        end

        restart = fail && cfg.repeat_on && !cmd.second_pass;
        if (restart) begin
            crc_next      = CRC_INIT;
            pos_next      = 12'd0;
            cursor_next   = 7'd0;
            slot_next     = '0;
            restarts_next = restarts_reg + 16'd1;
            sh            = cfg.lead_pattern;
            ow            = lc;
            src           = 1'b0;
        end

        ow_m1       = ow - 5'd1;
        bit_val     = (ow != 5'd0) ? sh[ow_m1[3:0]] : 1'b0;
        done_val    = fail && !cfg.repeat_on;
        need_reread = restart && (lc == 5'd0);

        shift_next = sh;
        src_next   = src;
        if (ow != 5'd0) begin
            owed_next = ow_m1;
            if (src) begin
                crc_next = crc_step(crc_reg, bit_val);
            end
        end
    end

    assign stat.out_busy    = m_valid_reg && !m_tready;
    assign stat.need_reread = need_reread;

    // Cursor and CRC state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= 16'd0;
            owed_reg     <= 5'd0;
            pos_reg      <= 12'd0;
            cursor_reg   <= 7'd0;
            slot_reg     <= '0;
            crc_reg      <= CRC_INIT;
            restarts_reg <= 16'd0;
            src_reg      <= 1'b0;
        end else if (cmd.step) begin
            shift_reg    <= shift_next;
            owed_reg     <= owed_next;
            pos_reg      <= pos_next;
            cursor_reg   <= cursor_next;
            slot_reg     <= slot_next;
            crc_reg      <= crc_next;
            restarts_reg <= restarts_next;
            src_reg      <= src_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.step && !need_reread) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.step && !need_reread) begin
            m_bit_reg   <= bit_val;
            m_done_reg  <= done_val;
            m_count_reg <= restarts_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_bit    = m_bit_reg;
    assign m_done   = m_done_reg;
    assign m_count  = m_count_reg;

endmodule

`default_nettype wire

@@ sv/message_bit_serializer_crc.sv @@
`default_nettype none

// Message bit serializer with CRC-16-CCITT framing. Characters are written into
// a message store through the input stream (tuser high), and each request with
// tuser low returns the next bit of the message, most significant bit of each
// character first. With the CRC on, the CRC (polynomial 0x1021, start 0xFFFF)
// over the message bits follows, then four ones. At the end the block either
// reports done on every request or restarts with the lead pattern and counts
// the restart. A character write is stored straight from the idle state. A bit
// request is first accepted while the store read is registered, then the piece
// is picked and the bit taken. A restart with no lead bits needs a second
// store read of the first slot. A result still waiting on the output holds
// the request before its bit is taken.
module message_bit_serializer_crc
    import mbsc_pkg::*;
#(
    parameter int MSG_CHARS  = 64,
    parameter int CHAR_WIDTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // char_index [5:0], char_value [21:6], zero [23:22]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation [0]
    input  wire logic                 s_tuser,
    // Result stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // bit_out [0], done_res [1], repeat_count [17:2], zero [23:18]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    cfg_t        cfg;
    cmd_t        cmd;
    stat_t       stat;
    logic        m_bit;
    logic        m_done;
    logic [15:0] m_count;

    mbsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mbsc_dpath #(
        .MSG_CHARS  (MSG_CHARS),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .cmd        (cmd),
        .stat       (stat),
        .char_index (s_tdata[5:0]),
        .char_value (s_tdata[21:6]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_bit      (m_bit),
        .m_done     (m_done),
        .m_count    (m_count)
    );

    assign m_tdata = {6'd0, m_count, m_done, m_bit};

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import mbsc_pkg::*;

    localparam int MSG_SLOTS   = 64;
    localparam int HOLD_CYCLES = 8;
    localparam int QUIET_LIMIT = 1000;
    localparam int NUM_SEGS    = 12;
    localparam int SEG_ITEMS   = 100;
    localparam int NUM_DIR     = 35;

    // One serial bit as it leaves the block.
    typedef struct packed {
        logic        bit_out;
        logic        done_res;
        logic [15:0] repeat_count;
    } serial_res_t;

    // One line of the directed part: a register write or a request.
    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    reg_sel;
        logic [31:0] cfg_val;
        op_t         op;
        logic [5:0]  idx;
        logic [15:0] val;
        logic        typed;
        serial_res_t res;
    } dir_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Shadow of the serializer state.
    logic [15:0] slot_mem [0:MSG_SLOTS-1];
    logic [15:0] shifter     = '0;
    int          bits_left   = 0;
    int          pos         = 0;
    logic [6:0]  cursor      = '0;
    logic [15:0] crc_acc     = CRC_INIT;
    logic [15:0] restart_cnt = '0;

    // Shadow of the registers, at their reset values.
    logic [10:0] len_bits   = 11'd0;
    logic [4:0]  width_bits = 5'd10;
    logic        crc_en     = 1'b0;
    logic        rpt_en     = 1'b0;
    logic [15:0] lead_word  = 16'h0000;
    logic [4:0]  lead_bits  = 5'd0;

    serial_res_t serial_bits_due [$];
    serial_res_t want;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    dir_row_t dir_tab [NUM_DIR] = '{
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b1, '{1'b0, 1'b1, 16'd0}},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_WRITE,    6'd0,  16'hFFFF, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_WRITE,    6'd63, 16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_WRITE,    6'd1,  16'h8001, 1'b0, '0},
        '{1'b1, REG_REPEAT_ON,    32'd1, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'd1}},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'd2}},
        '{1'b1, REG_LEAD_PATTERN, 32'hFFFF, OP_NEXT_BIT, 6'd0, 16'h0000, 1'b0, '0},
        '{1'b1, REG_LEAD_COUNT,   32'd2, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b1, '{1'b1, 1'b0, 16'd3}},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_MESSAGE_BITS, 32'd3, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_CHAR_BITS,    32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_CRC_ON,       32'd1, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_MESSAGE_BITS, 32'd1, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_LEAD_COUNT,   32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_CHAR_BITS,    32'd31, OP_NEXT_BIT, 6'd0, 16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b1, REG_MESSAGE_BITS, 32'd1024, OP_NEXT_BIT, 6'd0, 16'h0000, 1'b0, '0},
        '{1'b1, REG_CHAR_BITS,    32'd16, OP_NEXT_BIT, 6'd0, 16'h0000, 1'b0, '0},
        '{1'b1, REG_REPEAT_ON,    32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_WRITE,    6'd2,  16'h5A3C, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0},
        '{1'b0, REG_MESSAGE_BITS, 32'd0, OP_NEXT_BIT, 6'd0,  16'h0000, 1'b0, '0}
    };

    message_bit_serializer_crc dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    // Shifts one message bit into the running CRC.
    function automatic void crc_feed(input logic b);
        logic fb;
        fb      = crc_acc[15] ^ b;
        crc_acc = {crc_acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    endfunction

    // Loads the next character, CRC or trailer into the shifter.
    // Returns zero once the message and its framing are used up.
    function automatic logic load_piece();
        int rem;
        int cw;
        int take;
        int k;
        rem = int'(len_bits) - pos;
        if (rem <= 0) begin
            if (rem == 0 && crc_en) begin
                shifter   = crc_acc;
                bits_left = 16;
                pos       = pos + 16;
                return 1'b1;
            end
            if (rem == -16) begin
                shifter   = TRAILER_WORD;
                bits_left = 4;
                pos       = pos + 4;
                return 1'b1;
            end
            return 1'b0;
        end
        // Character width saturates to 1..16.
        cw = (width_bits == 0) ? 1 : ((width_bits > 16) ? 16 : int'(width_bits));
        take = (cw < rem) ? cw : rem;
        shifter = (shifter << take) | slot_mem[cursor % MSG_SLOTS];
        // A character cut short by the message end does not move the cursor.
        if (cw <= rem) begin
            cursor = cursor + 7'd1;
        end
        pos       = pos + take;
        bits_left = take;
        if (crc_en) begin
            for (k = take; k > 0; k--) begin
                crc_feed(shifter[k-1]);
            end
        end
        return 1'b1;
    endfunction

    // Works out the result of one bit request and advances the shadow state.
    function automatic serial_res_t next_serial_bit();
        serial_res_t r;
        if (bits_left == 0 && !load_piece()) begin
            if (!rpt_en) begin
                r = '{1'b0, 1'b1, restart_cnt};
                return r;
            end
            crc_acc     = CRC_INIT;
            pos         = 0;
            cursor      = '0;
            restart_cnt = restart_cnt + 16'd1;
            shifter     = lead_word;
            bits_left   = (lead_bits > 16) ? 16 : int'(lead_bits);
            if (bits_left == 0 && !load_piece()) begin
                r = '{1'b0, 1'b0, restart_cnt};
                return r;
            end
        end
        bits_left = bits_left - 1;
        r = '{shifter[bits_left], 1'b0, restart_cnt};
        return r;
    endfunction

    // Sets how often the sender idles and the receiver stalls.
    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
        endcase
    endtask

    // Drives one request on the input stream and records what it should cause.
    task automatic send_item(input op_t op, input logic [5:0] idx, input logic [15:0] val,
                             input logic typed, input serial_res_t typed_res);
        int gap;
        serial_res_t r;
        gap = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 20) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({val, idx});
        do @(posedge aclk); while (!s_tready);
        if (op == OP_WRITE) begin
            slot_mem[idx] = val;
        end else begin
            r = next_serial_bit();
            serial_bits_due.push_back(typed ? typed_res : r);
        end
    endtask

    // Stops the input stream and lets the block drain before a register write.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (serial_bits_due.size() != 0) @(posedge aclk);
        repeat (HOLD_CYCLES) @(posedge aclk);
    endtask

    // One register write: setup, access, then the bus goes idle.
    task automatic apb_write(input reg_idx_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({r, 2'b00});
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_MESSAGE_BITS: len_bits   = v[10:0];
            REG_CHAR_BITS:    width_bits = v[4:0];
            REG_CRC_ON:       crc_en     = v[0];
            REG_REPEAT_ON:    rpt_en     = v[0];
            REG_LEAD_PATTERN: lead_word  = v[15:0];
            REG_LEAD_COUNT:   lead_bits  = v[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Receiver: random stalls, and each accepted result checked in order.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (serial_bits_due.size() == 0) begin
                $error("result with no request waiting: m_tdata=%h", m_tdata);
                mismatches++;
            end else begin
                want = serial_bits_due.pop_front();
                if (m_tdata[0] !== want.bit_out) begin
                    $error("bit_out: expected %0d, got %0d", want.bit_out, m_tdata[0]);
                    mismatches++;
                end
                if (m_tdata[1] !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, m_tdata[1]);
                    mismatches++;
                end
                if (m_tdata[17:2] !== want.repeat_count) begin
                    $error("repeat_count: expected %0d, got %0d",
                           want.repeat_count, m_tdata[17:2]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no request moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int i;
        int seg;
        int n;
        int pick;
        int msg_v;
        int cb_v;
        int crc_v;
        int rpt_v;
        int lead_v;
        int lc_v;
        logic after_item;
        op_t rop;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every slot first so that no read ever finds an unwritten one.
        set_idle_mode(0);
        for (i = 0; i < MSG_SLOTS; i++) begin
            send_item(OP_WRITE, 6'(i), 16'($urandom), 1'b0, '0);
        end

        // Directed part: done after reset, empty restarts, saturated widths,
        // lengths changed in the middle of a message.
        after_item = 1'b1;
        for (i = 0; i < NUM_DIR; i++) begin
            if (dir_tab[i].is_cfg) begin
                if (after_item) begin
                    quiesce();
                end
                apb_write(dir_tab[i].reg_sel, dir_tab[i].cfg_val);
                after_item = 1'b0;
            end else begin
                send_item(dir_tab[i].op, dir_tab[i].idx, dir_tab[i].val,
                          dir_tab[i].typed, dir_tab[i].res);
                after_item = 1'b1;
            end
        end

        // Random part: a new setting per segment, mostly bit requests with a
        // few character rewrites. The state runs on across segments.
        for (seg = 0; seg < NUM_SEGS; seg++) begin
            quiesce();
            set_idle_mode(seg % 4);
            if (seg == 0) begin
                msg_v = 1024; cb_v = 16; crc_v = 1; rpt_v = 1; lead_v = 16'hFFFF; lc_v = 16;
            end else if (seg == 1) begin
                msg_v = 0; cb_v = 1; crc_v = 1; rpt_v = 1; lead_v = 0; lc_v = 0;
            end else begin
                pick = $urandom_range(99);
                if (pick < 20) begin
                    msg_v = $urandom_range(8);
                end else if (pick < 80) begin
                    msg_v = $urandom_range(48, 9);
                end else if (pick < 95) begin
                    msg_v = $urandom_range(200, 49);
                end else begin
                    msg_v = $urandom_range(1024, 201);
                end
                cb_v   = ($urandom_range(99) < 75) ? $urandom_range(16, 1) : $urandom_range(31);
                crc_v  = $urandom_range(1);
                rpt_v  = ($urandom_range(99) < 80) ? 1 : 0;
                lead_v = $urandom_range(16'hFFFF);
                lc_v   = ($urandom_range(99) < 80) ? $urandom_range(16) : $urandom_range(31, 17);
            end
            apb_write(REG_MESSAGE_BITS, 32'(msg_v));
            apb_write(REG_CHAR_BITS,    32'(cb_v));
            apb_write(REG_CRC_ON,       32'(crc_v));
            apb_write(REG_REPEAT_ON,    32'(rpt_v));
            apb_write(REG_LEAD_PATTERN, 32'(lead_v));
            apb_write(REG_LEAD_COUNT,   32'(lc_v));
            for (n = 0; n < SEG_ITEMS; n++) begin
                rop = ($urandom_range(99) < 12) ? OP_WRITE : OP_NEXT_BIT;
                send_item(rop, 6'($urandom_range(63)), 16'($urandom), 1'b0, '0);
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
